// ===== rtl/amt_pkg.sv =====
// amt_pkg: shared types and constants of the alarm match table
// used by amt_cell and alarm_match_table; no dependencies
package amt_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [2:0] FLD_WEEKDAY = 3'd0;
    localparam logic [2:0] FLD_HOUR    = 3'd1;
    localparam logic [2:0] FLD_MINUTE  = 3'd2;
    localparam logic [2:0] FLD_KIND    = 3'd3;
    localparam logic [2:0] FLD_ENABLE  = 3'd4;
    localparam logic [2:0] FLD_PENDING = 3'd5;

    // words of result data that move down the cell chain, eight per cycle
    localparam int LANES = 8;

    typedef struct packed {
        logic       do_write;
        logic       do_read;
        logic       do_tick;
        logic [2:0] sel;
        logic [6:0] idx;
        logic [5:0] val;
        logic [2:0] now_weekday;
        logic [4:0] now_hour;
        logic [5:0] now_minute;
    } t_cmd;

    typedef struct packed {
        logic       flag;
        logic [5:0] data;
    } t_word;

    function automatic logic sel_valid(input logic [2:0] sel);
        logic ok;
        case (sel)
            FLD_WEEKDAY, FLD_HOUR, FLD_MINUTE, FLD_KIND, FLD_ENABLE, FLD_PENDING: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic [5:0] field_limit(input logic [2:0] sel);
        logic [5:0] lim;
        case (sel)
            FLD_WEEKDAY: lim = 6'd6;
            FLD_HOUR:    lim = 6'd23;
            FLD_MINUTE:  lim = 6'd59;
            FLD_KIND:    lim = 6'd2;
            FLD_ENABLE:  lim = 6'd1;
            FLD_PENDING: lim = 6'd1;
            default:     lim = 6'd0;
        endcase
        return lim;
    endfunction

endpackage

// ===== rtl/amt_cell.sv =====
// amt_cell: one alarm entry with its own match compare and a result word stage
// depends on amt_pkg; instantiated in a chain by alarm_match_table
module amt_cell
    import amt_pkg::*;
#(
    parameter int CELL_ID = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  logic  i_load,
    input  logic  i_shift,
    input  t_word i_next,
    output t_word o_word
);

    logic [2:0] r_weekday, n_weekday;
    logic [4:0] r_hour, n_hour;
    logic [5:0] r_minute, n_minute;
    logic [1:0] r_kind, n_kind;
    logic       r_enable, n_enable;
    logic       r_pending, n_pending;
    t_word      r_word, n_word;

    logic hit;
    logic match;

    assign hit   = ({1'b0, i_cmd.idx} == 8'(CELL_ID));
    assign match = r_enable && (r_weekday == i_cmd.now_weekday)
                   && (r_hour == i_cmd.now_hour) && (r_minute == i_cmd.now_minute);

    always_comb begin
        n_weekday = r_weekday;
        n_hour    = r_hour;
        n_minute  = r_minute;
        n_kind    = r_kind;
        n_enable  = r_enable;
        n_pending = r_pending;
        n_word    = r_word;
        if (i_load) begin
            n_word = '0;
            if (i_cmd.do_write && hit) begin
                case (i_cmd.sel)
                    FLD_WEEKDAY: n_weekday = i_cmd.val[2:0];
                    FLD_HOUR:    n_hour    = i_cmd.val[4:0];
                    FLD_MINUTE:  n_minute  = i_cmd.val;
                    FLD_KIND:    n_kind    = i_cmd.val[1:0];
                    FLD_ENABLE:  n_enable  = i_cmd.val[0];
                    FLD_PENDING: begin
                        n_pending   = i_cmd.val[0];
                        n_word.flag = r_pending ^ i_cmd.val[0];
                    end
                    default: ;
                endcase
            end
            if (i_cmd.do_read && hit) begin
                case (i_cmd.sel)
                    FLD_WEEKDAY: n_word.data = {3'b000, r_weekday};
                    FLD_HOUR:    n_word.data = {1'b0, r_hour};
                    FLD_MINUTE:  n_word.data = r_minute;
                    FLD_KIND:    n_word.data = {4'b0000, r_kind};
                    FLD_ENABLE:  n_word.data = {5'b00000, r_enable};
                    FLD_PENDING: n_word.data = {5'b00000, r_pending};
                    default:     n_word.data = 6'd0;
                endcase
            end
            if (i_cmd.do_tick) begin
                // count only entries that become pending
                n_word.flag = match && !r_pending;
                n_pending   = r_pending || match;
            end
        end else if (i_shift) begin
            n_word = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weekday <= '0;
            r_hour    <= '0;
            r_minute  <= '0;
            r_kind    <= '0;
            r_enable  <= 1'b0;
            r_pending <= 1'b0;
            r_word    <= '0;
        end else begin
            r_weekday <= n_weekday;
            r_hour    <= n_hour;
            r_minute  <= n_minute;
            r_kind    <= n_kind;
            r_enable  <= n_enable;
            r_pending <= n_pending;
            r_word    <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

// ===== rtl/alarm_match_table.sv =====
// alarm_match_table: top level, command capture, cell chain and result collection
// depends on amt_pkg and amt_cell
//
// A transaction is taken when start is high and busy is low. Each cell holds one entry and
// updates or reads it in the cycle after acceptance; the per-cell result words then shift
// down the chain eight cells per cycle into a collector at the head, and busy stays high until
// the result strobe. The result is on the outputs for exactly one cycle with o_valid high
// and cannot be held off; a new transaction may start in that cycle.
module alarm_match_table
    import amt_pkg::*;
#(
    parameter int ENTRIES = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_opcode,
    input  logic [2:0] i_field_select,
    input  logic [6:0] i_entry_index,
    input  logic [5:0] i_write_value,
    input  logic [2:0] i_now_weekday,
    input  logic [4:0] i_now_hour,
    input  logic [5:0] i_now_minute,
    output logic       o_valid,
    output logic [5:0] o_read_value,
    output logic [7:0] o_pending_count,
    output logic       o_error
);

    localparam int STEPS = (ENTRIES + LANES - 1) / LANES;
    localparam int NPAD  = STEPS * LANES;
    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int OW    = (CW > 8) ? CW : 8;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOAD   = 4'b0010,
        ST_SWEEP  = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    t_state         r_state, n_state;
    t_cmd           r_cmd, n_cmd;
    logic           r_err, n_err;
    logic [SW-1:0]  r_step, n_step;
    logic [CW-1:0]  r_acc, n_acc;
    logic [CW-1:0]  r_count, n_count;
    logic [5:0]     r_rd, n_rd;
    logic           r_valid, n_valid;
    logic [5:0]     r_out_rd, n_out_rd;
    logic [7:0]     r_out_cnt, n_out_cnt;
    logic           r_out_err, n_out_err;

    t_word          w_word [NPAD];
    logic           cell_load;
    logic           cell_shift;
    logic [CW-1:0]  head_sum;
    logic [5:0]     head_or;
    logic [CW-1:0]  new_count;
    logic [OW-1:0]  count_ext;
    logic           accept;

    assign accept     = start && (r_state == ST_IDLE);
    assign cell_load  = (r_state == ST_LOAD);
    assign cell_shift = (r_state == ST_SWEEP);

    for (genvar i = 0; i < NPAD; i++) begin : g_cell
        if (i < ENTRIES) begin : g_real
            t_word next_word;
            if (i + LANES < NPAD) begin : g_mid
                assign next_word = w_word[i + LANES];
            end else begin : g_end
                assign next_word = '0;
            end
            amt_cell #(
                .CELL_ID(i)
            ) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_cmd  (r_cmd),
                .i_load (cell_load),
                .i_shift(cell_shift),
                .i_next (next_word),
                .o_word (w_word[i])
            );
        end else begin : g_pad
            assign w_word[i] = '0;
        end
    end

    always_comb begin
        head_sum = '0;
        head_or  = '0;
        for (int l = 0; l < LANES; l++) begin
            head_sum = head_sum + CW'(w_word[l].flag);
            head_or  = head_or | w_word[l].data;
        end
    end

    always_comb begin
        new_count = r_count;
        if (r_cmd.do_tick) begin
            new_count = CW'(r_count + r_acc);
        end else if (r_cmd.do_write && (r_cmd.sel == FLD_PENDING)) begin
            new_count = r_cmd.val[0] ? CW'(r_count + r_acc) : CW'(r_count - r_acc);
        end
    end

    assign count_ext = OW'(new_count);

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_err     = r_err;
        n_step    = r_step;
        n_acc     = r_acc;
        n_count   = r_count;
        n_rd      = r_rd;
        n_valid   = 1'b0;
        n_out_rd  = r_out_rd;
        n_out_cnt = r_out_cnt;
        n_out_err = r_out_err;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cmd.do_write = (i_opcode == OP_WRITE) && sel_valid(i_field_select)
                                     && (i_write_value <= field_limit(i_field_select));
                    n_cmd.do_read  = (i_opcode == OP_READ) && sel_valid(i_field_select);
                    n_cmd.do_tick  = (i_opcode == OP_TICK);
                    n_cmd.sel         = i_field_select;
                    n_cmd.idx         = i_entry_index;
                    n_cmd.val         = i_write_value;
                    n_cmd.now_weekday = i_now_weekday;
                    n_cmd.now_hour    = i_now_hour;
                    n_cmd.now_minute  = i_now_minute;
                    n_err = !(n_cmd.do_write || n_cmd.do_read || n_cmd.do_tick)
                            && (i_opcode != OP_WRITE || !sel_valid(i_field_select)
                                || (i_write_value > field_limit(i_field_select))
                                || !(i_opcode == OP_WRITE));
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_step  = '0;
                n_acc   = '0;
                n_rd    = '0;
                n_state = ST_SWEEP;
            end
            ST_SWEEP: begin
                n_acc  = CW'(r_acc + head_sum);
                n_rd   = r_rd | head_or;
                n_step = SW'(r_step + 1'b1);
                if (r_step == SW'(STEPS - 1)) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_count   = new_count;
                n_valid   = 1'b1;
                n_out_rd  = r_rd;
                n_out_cnt = (count_ext > OW'(255)) ? 8'hFF : count_ext[7:0];
                n_out_err = r_err;
                n_state   = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_valid   <= 1'b0;
            r_step    <= '0;
            r_acc     <= '0;
            r_cmd     <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_valid   <= n_valid;
            r_step    <= n_step;
            r_acc     <= n_acc;
            r_cmd     <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_err     <= n_err;
        r_rd      <= n_rd;
        r_out_rd  <= n_out_rd;
        r_out_cnt <= n_out_cnt;
        r_out_err <= n_out_err;
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_valid         = r_valid;
    assign o_read_value    = r_out_rd;
    assign o_pending_count = r_out_cnt;
    assign o_error         = r_out_err;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after accepted transaction");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ENTRIES))
        else $error("pending count exceeds entry count");

    a_error_zero_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (o_read_value == 6'd0))
        else $error("rejected transaction returned read data");
`endif

endmodule

// ===== tb/alarm_match_tb_pkg.sv =====
`timescale 1ns / 100ps
// alarm_match_tb_pkg: expected-result predictor and scoreboard for the alarm match table
// depends on amt_pkg for opcode and field codes
package alarm_match_tb_pkg;
    import amt_pkg::*;

    localparam int         TABLE_DEPTH = 128;
    localparam logic [1:0] OP_NONE     = 2'd3;

    typedef struct packed {
        logic [5:0] read_value;
        logic [7:0] pending_count;
        logic       error;
    } t_alarm_result;

    class alarm_scoreboard;
        bit [2:0] weekday_mem [TABLE_DEPTH];
        bit [4:0] hour_mem    [TABLE_DEPTH];
        bit [5:0] minute_mem  [TABLE_DEPTH];
        bit [1:0] kind_mem    [TABLE_DEPTH];
        bit       enable_mem  [TABLE_DEPTH];
        bit       pending_mem [TABLE_DEPTH];
        t_alarm_result expected_q[$];
        int mismatches;
        int n_writes;
        int n_reads;
        int n_ticks;
        int n_rejected;
        int n_checked;
        int peak_count;

        function bit field_ok(input logic [2:0] sel);
            case (sel)
                FLD_WEEKDAY, FLD_HOUR, FLD_MINUTE, FLD_KIND, FLD_ENABLE, FLD_PENDING: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function logic [5:0] field_max(input logic [2:0] sel);
            case (sel)
                FLD_WEEKDAY: return 6'd6;
                FLD_HOUR:    return 6'd23;
                FLD_MINUTE:  return 6'd59;
                FLD_KIND:    return 6'd2;
                FLD_ENABLE:  return 6'd1;
                FLD_PENDING: return 6'd1;
                default:     return 6'd0;
            endcase
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        function void note_command(input logic [1:0] op, input logic [2:0] sel,
                                   input logic [6:0] idx, input logic [5:0] val,
                                   input logic [2:0] wday, input logic [4:0] hour,
                                   input logic [5:0] minute);
            t_alarm_result res;
            int cnt;
            res = '0;
            case (op)
                OP_WRITE: begin
                    n_writes++;
                    if (!field_ok(sel) || val > field_max(sel)) begin
                        res.error = 1'b1;
                    end else begin
                        case (sel)
                            FLD_WEEKDAY: weekday_mem[idx] = val[2:0];
                            FLD_HOUR:    hour_mem[idx]    = val[4:0];
                            FLD_MINUTE:  minute_mem[idx]  = val;
                            FLD_KIND:    kind_mem[idx]    = val[1:0];
                            FLD_ENABLE:  enable_mem[idx]  = val[0];
                            FLD_PENDING: pending_mem[idx] = val[0];
                            default: ;
                        endcase
                    end
                end
                OP_READ: begin
                    n_reads++;
                    case (sel)
                        FLD_WEEKDAY: res.read_value = {3'd0, weekday_mem[idx]};
                        FLD_HOUR:    res.read_value = {1'd0, hour_mem[idx]};
                        FLD_MINUTE:  res.read_value = minute_mem[idx];
                        FLD_KIND:    res.read_value = {4'd0, kind_mem[idx]};
                        FLD_ENABLE:  res.read_value = {5'd0, enable_mem[idx]};
                        FLD_PENDING: res.read_value = {5'd0, pending_mem[idx]};
                        default:     res.error = 1'b1;
                    endcase
                end
                OP_TICK: begin
                    n_ticks++;
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (enable_mem[i] && weekday_mem[i] == wday && hour_mem[i] == hour &&
                            minute_mem[i] == minute) begin
                            pending_mem[i] = 1'b1;
                        end
                    end
                end
                default: res.error = 1'b1;
            endcase
            if (res.error) n_rejected++;
            cnt = 0;
            foreach (pending_mem[i]) cnt += pending_mem[i];
            res.pending_count = (cnt > 255) ? 8'd255 : cnt[7:0];
            if (cnt > peak_count) peak_count = cnt;
            expected_q.push_back(res);
        endfunction

        function void check_result(input logic [5:0] rd, input logic [7:0] cnt,
                                   input logic err);
            t_alarm_result want;
            if (expected_q.size() == 0) begin
                $error("result with no transaction outstanding: %s %0d %0d %0d",
                       "read_value, pending_count, error", rd, cnt, err);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            if (rd !== want.read_value) begin
                $error("read_value: expected %0d, actual %0d", want.read_value, rd);
                mismatches++;
            end
            if (cnt !== want.pending_count) begin
                $error("pending_count: expected %0d, actual %0d", want.pending_count, cnt);
                mismatches++;
            end
            if (err !== want.error) begin
                $error("error: expected %0d, actual %0d", want.error, err);
                mismatches++;
            end
        endfunction
    endclass

endpackage

// ===== tb/tb_alarm_match_table.sv =====
`timescale 1ns / 100ps
// tb_alarm_match_table: directed and random transactions against the alarm match table
// depends on amt_pkg, alarm_match_tb_pkg and the alarm_match_table rtl
module tb_alarm_match_table;
    import amt_pkg::*;
    import alarm_match_tb_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int SETTLE_CYCLES = 40;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [1:0] i_opcode = '0;
    logic [2:0] i_field_select = '0;
    logic [6:0] i_entry_index = '0;
    logic [5:0] i_write_value = '0;
    logic [2:0] i_now_weekday = '0;
    logic [4:0] i_now_hour = '0;
    logic [5:0] i_now_minute = '0;
    logic       o_valid;
    logic [5:0] o_read_value;
    logic [7:0] o_pending_count;
    logic       o_error;

    alarm_scoreboard sb;
    bit          idle_enable = 1'b1;
    int          items_sent = 0;
    logic [2:0]  pool_wday [4];
    logic [4:0]  pool_hour [4];
    logic [5:0]  pool_min  [4];

    alarm_match_table dut (
        .i_clk,
        .i_rst_n,
        .start,
        .busy,
        .i_opcode,
        .i_field_select,
        .i_entry_index,
        .i_write_value,
        .i_now_weekday,
        .i_now_hour,
        .i_now_minute,
        .o_valid,
        .o_read_value,
        .o_pending_count,
        .o_error
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_read_value, o_pending_count, o_error);
    end

    task automatic send_cmd(input logic [1:0] op, input logic [2:0] sel,
                            input logic [6:0] idx, input logic [5:0] val,
                            input logic [2:0] wday, input logic [4:0] hour,
                            input logic [5:0] minute);
        int gap;
        gap = 0;
        if (idle_enable && $urandom_range(99) < 13) gap = $urandom_range(1, 24);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start          <= 1'b1;
        i_opcode       <= op;
        i_field_select <= sel;
        i_entry_index  <= idx;
        i_write_value  <= val;
        i_now_weekday  <= wday;
        i_now_hour     <= hour;
        i_now_minute   <= minute;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_command(op, sel, idx, val, wday, hour, minute);
        items_sent++;
    endtask

    task automatic pause_until_empty();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int          pick;
        int          slot;
        int          target;
        bit          paused_mid;
        logic [6:0]  idx;

        sb = new();
        paused_mid = 1'b0;
        foreach (pool_wday[i]) begin
            pool_wday[i] = 3'($urandom_range(6));
            pool_hour[i] = 5'($urandom_range(23));
            pool_min[i]  = 6'($urandom_range(59));
        end
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset contents, field extremes, rejects, ticks, opcode 3
        send_cmd(OP_READ,  FLD_WEEKDAY, 7'd0,   6'd0,  3'd0, 5'd0,  6'd0);
        send_cmd(OP_READ,  FLD_PENDING, 7'd127, 6'd0,  3'd0, 5'd0,  6'd0);
        send_cmd(OP_TICK,  FLD_WEEKDAY, 7'd0,   6'd0,  3'd0, 5'd0,  6'd0);
        send_cmd(OP_WRITE, FLD_WEEKDAY, 7'd127, 6'd6,  3'd0, 5'd0,  6'd0);
        send_cmd(OP_WRITE, FLD_HOUR,    7'd127, 6'd23, 3'd0, 5'd0,  6'd0);
        send_cmd(OP_WRITE, FLD_MINUTE,  7'd127, 6'd59, 3'd0, 5'd0,  6'd0);
        send_cmd(OP_WRITE, FLD_KIND,    7'd127, 6'd2,  3'd0, 5'd0,  6'd0);
        send_cmd(OP_WRITE, FLD_ENABLE,  7'd127, 6'd1,  3'd0, 5'd0,  6'd0);
        send_cmd(OP_WRITE, FLD_WEEKDAY, 7'd5,   6'd7,  3'd0, 5'd0,  6'd0);
        send_cmd(OP_WRITE, FLD_HOUR,    7'd5,   6'd63, 3'd0, 5'd0,  6'd0);
        send_cmd(OP_WRITE, FLD_MINUTE,  7'd5,   6'd60, 3'd0, 5'd0,  6'd0);
        send_cmd(OP_WRITE, FLD_KIND,    7'd5,   6'd3,  3'd0, 5'd0,  6'd0);
        send_cmd(OP_WRITE, FLD_ENABLE,  7'd5,   6'd2,  3'd0, 5'd0,  6'd0);
        send_cmd(OP_WRITE, FLD_PENDING, 7'd5,   6'd2,  3'd0, 5'd0,  6'd0);
        send_cmd(OP_WRITE, 3'd6,        7'd5,   6'd0,  3'd0, 5'd0,  6'd0);
        send_cmd(OP_READ,  3'd7,        7'd127, 6'd0,  3'd0, 5'd0,  6'd0);
        send_cmd(OP_TICK,  3'd7,        7'd127, 6'd63, 3'd6, 5'd23, 6'd59);
        send_cmd(OP_TICK,  3'd6,        7'd127, 6'd63, 3'd7, 5'd31, 6'd63);
        send_cmd(OP_NONE,  FLD_HOUR,    7'd127, 6'd1,  3'd6, 5'd23, 6'd59);
        send_cmd(OP_READ,  FLD_PENDING, 7'd127, 6'd0,  3'd0, 5'd0,  6'd0);
        send_cmd(OP_READ,  FLD_MINUTE,  7'd127, 6'd0,  3'd0, 5'd0,  6'd0);
        send_cmd(OP_WRITE, FLD_PENDING, 7'd127, 6'd0,  3'd0, 5'd0,  6'd0);
        send_cmd(OP_WRITE, FLD_PENDING, 7'd0,   6'd1,  3'd0, 5'd0,  6'd0);
        pause_until_empty();

        // random: mostly entry programming and ticks on a small pool of times
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            idle_enable = !(items_sent >= 500 && items_sent < 800);
            if (!paused_mid && items_sent >= 700) begin
                pause_until_empty();
                paused_mid = 1'b1;
            end
            pick = $urandom_range(99);
            slot = $urandom_range(3);
            idx  = 7'($urandom_range(127));
            if (pick < 35) begin
                send_cmd(OP_WRITE, FLD_WEEKDAY, idx, 6'(pool_wday[slot]), 3'd0, 5'd0, 6'd0);
                send_cmd(OP_WRITE, FLD_HOUR,    idx, 6'(pool_hour[slot]), 3'd0, 5'd0, 6'd0);
                send_cmd(OP_WRITE, FLD_MINUTE,  idx, pool_min[slot],      3'd0, 5'd0, 6'd0);
                send_cmd(OP_WRITE, FLD_KIND,    idx, 6'($urandom_range(2)), 3'd0, 5'd0, 6'd0);
                send_cmd(OP_WRITE, FLD_ENABLE,  idx, 6'd1,                3'd0, 5'd0, 6'd0);
            end else if (pick < 55) begin
                send_cmd(OP_TICK, 3'($urandom_range(7)), 7'($urandom_range(127)),
                         6'($urandom_range(63)), pool_wday[slot], pool_hour[slot],
                         pool_min[slot]);
            end else if (pick < 70) begin
                send_cmd(OP_READ, 3'($urandom_range(5)), idx, 6'($urandom_range(63)),
                         3'd0, 5'd0, 6'd0);
            end else if (pick < 78) begin
                send_cmd(OP_WRITE, ($urandom_range(1) != 0) ? FLD_PENDING : FLD_ENABLE, idx,
                         6'($urandom_range(1)), 3'd0, 5'd0, 6'd0);
            end else if (pick < 80) begin
                pool_wday[slot] = 3'($urandom_range(6));
                pool_hour[slot] = 5'($urandom_range(23));
                pool_min[slot]  = 6'($urandom_range(59));
            end else begin
                send_cmd(2'($urandom_range(3)), 3'($urandom_range(7)), idx,
                         6'($urandom_range(63)), 3'($urandom_range(7)),
                         5'($urandom_range(31)), 6'($urandom_range(63)));
            end
        end

        pause_until_empty();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d transactions: %0d writes, %0d reads, %0d ticks, %0d rejected",
                 items_sent, sb.n_writes, sb.n_reads, sb.n_ticks, sb.n_rejected);
        $display("checked %0d results, pending count peaked at %0d, %0d mismatches",
                 sb.n_checked, sb.peak_count, sb.mismatches);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
